// ----- src/nir_pkg.sv -----
// shared types and constants of the nec infrared frame decoder
package nir_pkg;

    // configuration register map and reset values
    localparam int unsigned APB_ADDR_W = 4;
    localparam logic [1:0] REG_TICK_US        = 2'd0;
    localparam logic [1:0] REG_TOLERANCE_PCT  = 2'd1;
    localparam logic [1:0] REG_MARK_EXCESS_US = 2'd2;

    localparam logic [7:0] TICK_US_RST        = 8'd50;
    localparam logic [5:0] TOLERANCE_PCT_RST  = 6'd25;
    localparam logic [7:0] MARK_EXCESS_US_RST = 8'd100;

    typedef struct packed {
        logic [7:0] tick_us;
        logic [5:0] tolerance_pct;
        logic [7:0] mark_excess_us;
    } cfg_t;

    // pulse classes checked for every entry
    localparam int unsigned NUM_MATCH    = 6;
    localparam int unsigned M_HDR_MARK   = 0;
    localparam int unsigned M_HDR_SPACE  = 1;
    localparam int unsigned M_RPT_SPACE  = 2;
    localparam int unsigned M_BIT_MARK   = 3;
    localparam int unsigned M_ONE_SPACE  = 4;
    localparam int unsigned M_ZERO_SPACE = 5;

    localparam int unsigned DES_W = 14;
    localparam logic [DES_W-1:0] DESIRED_US [NUM_MATCH] = '{
        14'd9000, 14'd4500, 14'd2250, 14'd560, 14'd1690, 14'd560
    };
    localparam logic [NUM_MATCH-1:0] IS_MARK = 6'b001001;

    // tolerance bounds: largest is (9000+255)*163 + 255*100, below 2**21
    localparam int unsigned BND_W    = 21;
    localparam int unsigned PCT_FULL = 100;

    // classified entry passed from front to back
    typedef struct packed {
        logic [NUM_MATCH-1:0] hit;
        logic                 frame_start;
        logic                 frame_end;
    } cls_item_t;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int unsigned POS_W = 7;

    typedef enum logic [1:0] {
        STATUS_NONE   = 2'd0,
        STATUS_DATA   = 2'd1,
        STATUS_REPEAT = 2'd2
    } status_t;

endpackage

// ----- src/nir_if.sv -----
// stream interfaces for pulse entries and decoded frames
interface nir_in_if #(
    parameter int unsigned DURATION_WIDTH = 16
);
    logic                      valid;
    logic                      ready;
    logic [DURATION_WIDTH-1:0] duration;
    logic                      frame_start;
    logic                      frame_end;

    modport source (output valid, duration, frame_start, frame_end, input ready);
    modport sink   (input valid, duration, frame_start, frame_end, output ready);
endinterface

interface nir_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] frame_value;
    logic [7:0]  device_address;
    logic [7:0]  key_command;
    logic [5:0]  bit_count;

    modport source (output valid, status, frame_value, device_address, key_command,
                    bit_count, input ready);
    modport sink   (input valid, status, frame_value, device_address, key_command,
                    bit_count, output ready);
endinterface

// ----- src/nir_front.sv -----
// front end: scales each duration and matches it against all pulse classes
module nir_front #(
    parameter int unsigned DURATION_WIDTH = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  nir_pkg::cfg_t       cfg,
    nir_in_if.sink              in_ch,
    output logic                push_valid,
    input  logic                push_ready,
    output nir_pkg::cls_item_t  push_item
);

    localparam int unsigned PROD_W = DURATION_WIDTH + 8;
    localparam int unsigned LHS_W  = PROD_W + 7;

    logic [nir_pkg::BND_W-1:0] lo_reg  [nir_pkg::NUM_MATCH];
    logic [nir_pkg::BND_W-1:0] hi_reg  [nir_pkg::NUM_MATCH];
    logic [nir_pkg::BND_W-1:0] lo_next [nir_pkg::NUM_MATCH];
    logic [nir_pkg::BND_W-1:0] hi_next [nir_pkg::NUM_MATCH];
    logic [nir_pkg::BND_W-1:0] scaled_tick;
    logic [nir_pkg::BND_W-1:0] dev_us;

    logic              s1_valid_reg;
    logic [PROD_W-1:0] prod_reg;
    logic              start_reg;
    logic              end_reg;
    logic [LHS_W-1:0]  lhs;
    logic              accept;

    // match window per class, rebuilt from the registers every cycle
    always_comb
    begin
        scaled_tick = nir_pkg::BND_W'(cfg.tick_us) * nir_pkg::BND_W'(nir_pkg::PCT_FULL);
        dev_us      = '0;
        for (int k = 0; k < nir_pkg::NUM_MATCH; k++)
        begin
            if (nir_pkg::IS_MARK[k])
                dev_us = nir_pkg::BND_W'(nir_pkg::DESIRED_US[k])
                       + nir_pkg::BND_W'(cfg.mark_excess_us);
            else
                dev_us = nir_pkg::BND_W'(nir_pkg::DESIRED_US[k])
                       - nir_pkg::BND_W'(cfg.mark_excess_us);
            lo_next[k] = dev_us * (nir_pkg::BND_W'(nir_pkg::PCT_FULL)
                                   - nir_pkg::BND_W'(cfg.tolerance_pct));
            hi_next[k] = dev_us * (nir_pkg::BND_W'(nir_pkg::PCT_FULL)
                                   + nir_pkg::BND_W'(cfg.tolerance_pct)) + scaled_tick;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < nir_pkg::NUM_MATCH; k++)
        begin
            lo_reg[k] <= lo_next[k];
            hi_reg[k] <= hi_next[k];
        end
    end

    assign in_ch.ready = !s1_valid_reg || push_ready;
    assign accept      = in_ch.valid && in_ch.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (accept)
            s1_valid_reg <= 1'b1;
        else if (push_ready)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prod_reg  <= PROD_W'(in_ch.duration) * PROD_W'(cfg.tick_us);
            start_reg <= in_ch.frame_start;
            end_reg   <= in_ch.frame_end;
        end
    end

    // times 100 as shift-add
    assign lhs = (LHS_W'(prod_reg) << 6) + (LHS_W'(prod_reg) << 5) + (LHS_W'(prod_reg) << 2);

    always_comb
    begin
        push_item.frame_start = start_reg;
        push_item.frame_end   = end_reg;
        for (int k = 0; k < nir_pkg::NUM_MATCH; k++)
            push_item.hit[k] = (lhs >= LHS_W'(lo_reg[k])) && (lhs <= LHS_W'(hi_reg[k]));
    end

    assign push_valid = s1_valid_reg;

endmodule

// ----- src/nir_queue.sv -----
// small fifo between the classifier and the frame sequencer
module nir_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    output logic               push_ready,
    input  nir_pkg::cls_item_t push_item,
    output logic               pop_valid,
    input  logic               pop_ready,
    output nir_pkg::cls_item_t pop_item
);

    nir_pkg::cls_item_t               mem [nir_pkg::QUEUE_DEPTH];
    logic [nir_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [nir_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [nir_pkg::QCNT_W-1:0]       count_reg;
    logic [nir_pkg::QCNT_W-1:0]       count_next;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = count_reg != nir_pkg::QCNT_W'(nir_pkg::QUEUE_DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_item   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == nir_pkg::QPTR_W'(nir_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == nir_pkg::QPTR_W'(nir_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_item;
    end

endmodule

// ----- src/nir_back.sv -----
// back end: tracks the capture position, shifts in bits and builds the result
module nir_back #(
    parameter int unsigned DATA_BITS = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    output logic               pop_ready,
    input  nir_pkg::cls_item_t pop_item,
    nir_out_if.source          out_ch
);

    localparam int unsigned POS_W = nir_pkg::POS_W;
    localparam logic [POS_W-1:0] POS_HDR_MARK  = POS_W'(1);
    localparam logic [POS_W-1:0] POS_HDR_SPACE = POS_W'(2);
    localparam logic [POS_W-1:0] POS_FIRST_BIT = POS_W'(3);
    localparam logic [POS_W-1:0] POS_BIT_END   = POS_W'(3 + 2 * DATA_BITS);
    localparam logic [POS_W-1:0] POS_RPT_LEN   = POS_W'(4);
    localparam logic [POS_W-1:0] POS_DATA_LEN  = POS_W'(2 * DATA_BITS + 4);
    localparam logic [POS_W-1:0] POS_MAX       = {POS_W{1'b1}};
    localparam logic [5:0]       BIT_COUNT     = 6'(DATA_BITS);

    logic [POS_W-1:0] pos_reg;
    logic [31:0]      shift_reg;
    logic             data_ok_reg;
    logic             rpt_ok_reg;

    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] pos_next;
    logic [31:0]      shift_next;
    logic             data_ok_next;
    logic             rpt_ok_next;
    logic             pop;

    logic             out_valid_reg;
    nir_pkg::status_t status_reg;
    logic [31:0]      value_reg;
    logic [7:0]       addr_reg;
    logic [7:0]       cmd_reg;
    logic [5:0]       count_reg;

    nir_pkg::status_t status_next;
    logic [31:0]      value_next;
    logic [7:0]       addr_next;
    logic [7:0]       cmd_next;
    logic [5:0]       count_next;

    assign pop_ready = !out_valid_reg || out_ch.ready;
    assign pop       = pop_valid && pop_ready;

    always_comb
    begin
        pos          = pop_item.frame_start ? '0 : pos_reg;
        shift_next   = pop_item.frame_start ? '0 : shift_reg;
        data_ok_next = pop_item.frame_start ? 1'b1 : data_ok_reg;
        rpt_ok_next  = pop_item.frame_start ? 1'b1 : rpt_ok_reg;

        if (pos == POS_HDR_MARK)
        begin
            if (!pop_item.hit[nir_pkg::M_HDR_MARK])
            begin
                data_ok_next = 1'b0;
                rpt_ok_next  = 1'b0;
            end
        end
        else if (pos == POS_HDR_SPACE)
        begin
            if (!pop_item.hit[nir_pkg::M_RPT_SPACE])
                rpt_ok_next = 1'b0;
            if (!pop_item.hit[nir_pkg::M_HDR_SPACE])
                data_ok_next = 1'b0;
        end
        else if (pos >= POS_FIRST_BIT && pos < POS_BIT_END)
        begin
            if (pos == POS_FIRST_BIT && !pop_item.hit[nir_pkg::M_BIT_MARK])
                rpt_ok_next = 1'b0;
            // odd positions are bit marks, even ones bit spaces
            if (pos[0])
            begin
                if (!pop_item.hit[nir_pkg::M_BIT_MARK])
                    data_ok_next = 1'b0;
            end
            else if (pop_item.hit[nir_pkg::M_ONE_SPACE])
                shift_next = {shift_next[30:0], 1'b1};
            else if (pop_item.hit[nir_pkg::M_ZERO_SPACE])
                shift_next = {shift_next[30:0], 1'b0};
            else
                data_ok_next = 1'b0;
        end

        pos_next = (pos != POS_MAX) ? pos + 1'b1 : pos;

        status_next = nir_pkg::STATUS_NONE;
        value_next  = '0;
        addr_next   = '0;
        cmd_next    = '0;
        count_next  = '0;
        if (pos_next == POS_RPT_LEN && rpt_ok_next)
        begin
            status_next = nir_pkg::STATUS_REPEAT;
            value_next  = '1;
        end
        else if (pos_next >= POS_DATA_LEN && data_ok_next)
        begin
            status_next = nir_pkg::STATUS_DATA;
            value_next  = shift_next;
            count_next  = BIT_COUNT;
            for (int i = 0; i < 8; i++)
            begin
                addr_next[i] = shift_next[31 - i];
                cmd_next[i]  = shift_next[15 - i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            shift_reg     <= '0;
            data_ok_reg   <= 1'b1;
            rpt_ok_reg    <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (pop_item.frame_end)
                begin
                    pos_reg     <= '0;
                    shift_reg   <= '0;
                    data_ok_reg <= 1'b1;
                    rpt_ok_reg  <= 1'b1;
                end
                else
                begin
                    pos_reg     <= pos_next;
                    shift_reg   <= shift_next;
                    data_ok_reg <= data_ok_next;
                    rpt_ok_reg  <= rpt_ok_next;
                end
            end
            if (pop && pop_item.frame_end)
                out_valid_reg <= 1'b1;
            else if (out_ch.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && pop_item.frame_end)
        begin
            status_reg <= status_next;
            value_reg  <= value_next;
            addr_reg   <= addr_next;
            cmd_reg    <= cmd_next;
            count_reg  <= count_next;
        end
    end

    assign out_ch.valid          = out_valid_reg;
    assign out_ch.status         = status_reg;
    assign out_ch.frame_value    = value_reg;
    assign out_ch.device_address = addr_reg;
    assign out_ch.key_command    = cmd_reg;
    assign out_ch.bit_count      = count_reg;

endmodule

// ----- src/nec_ir_frame_decoder_unit.sv -----
// top level of the nec infrared frame decoder with its register port
// Decodes NEC infrared captures given as a stream of pulse durations in timer
// ticks (leading gap, then mark, space, mark ...), one entry per clock cycle
// sustained while nothing stalls. The front end registers duration*tick_us in
// one multiplier stage, then tests the scaled value against the tolerance
// windows of all six pulse classes at once and writes the outcome into a
// two-entry queue; the back end follows the capture position, shifts in bits
// MSB first and on the entry flagged as last registers one result (no match,
// data frame or repeat code). The last entry passes the front stage register
// and the queue before its result is registered; the input only waits while
// the front stage holds an entry and the queue is full, which takes a stalled
// result. Tolerance windows are recomputed from the registers in the cycle
// after each write, so an entry may follow a register write immediately.
module nec_ir_frame_decoder_unit #(
    parameter int unsigned DATA_BITS      = 32,
    parameter int unsigned DURATION_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [nir_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready,
    nir_in_if.sink                         in_ch,
    nir_out_if.source                      out_ch
);

    nir_pkg::cfg_t      cfg_reg;
    logic               cfg_wr;
    logic [1:0]         reg_idx;

    logic               fq_valid;
    logic               fq_ready;
    nir_pkg::cls_item_t fq_item;
    logic               qb_valid;
    logic               qb_ready;
    nir_pkg::cls_item_t qb_item;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.tick_us        <= nir_pkg::TICK_US_RST;
            cfg_reg.tolerance_pct  <= nir_pkg::TOLERANCE_PCT_RST;
            cfg_reg.mark_excess_us <= nir_pkg::MARK_EXCESS_US_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                nir_pkg::REG_TICK_US:        cfg_reg.tick_us        <= pwdata[7:0];
                nir_pkg::REG_TOLERANCE_PCT:  cfg_reg.tolerance_pct  <= pwdata[5:0];
                nir_pkg::REG_MARK_EXCESS_US: cfg_reg.mark_excess_us <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            nir_pkg::REG_TICK_US:        prdata = 32'(cfg_reg.tick_us);
            nir_pkg::REG_TOLERANCE_PCT:  prdata = 32'(cfg_reg.tolerance_pct);
            nir_pkg::REG_MARK_EXCESS_US: prdata = 32'(cfg_reg.mark_excess_us);
            default:                     prdata = '0;
        endcase
    end

    nir_front #(
        .DURATION_WIDTH(DURATION_WIDTH)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .in_ch      (in_ch),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item)
    );

    nir_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    nir_back #(
        .DATA_BITS(DATA_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (qb_valid),
        .pop_ready (qb_ready),
        .pop_item  (qb_item),
        .out_ch    (out_ch)
    );

    // the sequencer never overwrites a result that is still waiting
    a_no_result_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        qb_valid && qb_ready |-> !out_ch.valid || out_ch.ready)
        else $error("entry popped while a result is stalled");

    // a stalled classified entry is held by the front end
    a_front_holds: assert property (@(posedge clk) disable iff (!rst_n)
        fq_valid && !fq_ready |=> fq_valid && $stable(fq_item))
        else $error("front end dropped or changed a stalled entry");

    // a new result only follows a transaction out of the queue
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_ch.valid) |-> $past(qb_valid && qb_ready && qb_item.frame_end))
        else $error("result without a closing entry");

endmodule

// ----- tb/nir_frame_checker.sv -----
`timescale 1ns / 100ps
// frame checker: follows the pulse stream and register writes, predicts and compares frames
module nir_frame_checker
    import nir_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    nir_in_if                     pulse_ch,
    nir_out_if                    frame_ch,
    output int                    errors,
    output int                    pending,
    output int                    data_frames,
    output int                    repeat_frames,
    output int                    rejected_frames
);

    localparam int unsigned DATA_BITS     = 32;
    localparam int unsigned HDR_MARK_US   = 9000;
    localparam int unsigned HDR_SPACE_US  = 4500;
    localparam int unsigned BIT_MARK_US   = 560;
    localparam int unsigned ONE_SPACE_US  = 1690;
    localparam int unsigned ZERO_SPACE_US = 560;
    localparam int unsigned RPT_SPACE_US  = 2250;
    localparam logic [6:0]  POS_LIMIT     = 7'd127;

    typedef struct packed {
        status_t     status;
        logic [31:0] value;
        logic [7:0]  address;
        logic [7:0]  command;
        logic [5:0]  nbits;
    } frame_t;

    frame_t      frames_due[$];
    logic [7:0]  tick_us;
    logic [5:0]  tol_pct;
    logic [7:0]  excess_us;
    logic [6:0]  capture_pos;
    logic [31:0] bits_in;
    logic        data_ok;
    logic        repeat_ok;
    int          mismatches = 0;
    int          n_data = 0;
    int          n_repeat = 0;
    int          n_none = 0;

    // marks are stretched and spaces shortened by the excess before the window test
    function automatic bit pulse_fits(logic [15:0] dur, int unsigned desired_us, bit is_mark);
        longint unsigned target;
        longint unsigned scaled;
        longint unsigned lo;
        longint unsigned hi;
        target = is_mark ? desired_us + excess_us : desired_us - excess_us;
        scaled = dur;
        scaled = scaled * tick_us * 100;
        lo = target * (100 - tol_pct);
        hi = target * (100 + tol_pct) + tick_us * 100;
        return scaled >= lo && scaled <= hi;
    endfunction

    function automatic logic [7:0] flip_byte(logic [7:0] b);
        logic [7:0] r;
        for (int i = 0; i < 8; i++)
            r[i] = b[7 - i];
        return r;
    endfunction

    function automatic void clear_capture();
        capture_pos = '0;
        bits_in     = '0;
        data_ok     = 1'b1;
        repeat_ok   = 1'b1;
    endfunction

    function automatic void take_pulse(logic [15:0] dur, logic start_flag, logic end_flag);
        frame_t     result;
        logic [6:0] pos;
        if (start_flag)
            clear_capture();
        pos = capture_pos;
        if (pos == 7'd1)
        begin
            if (!pulse_fits(dur, HDR_MARK_US, 1'b1))
            begin
                data_ok   = 1'b0;
                repeat_ok = 1'b0;
            end
        end
        else if (pos == 7'd2)
        begin
            if (!pulse_fits(dur, RPT_SPACE_US, 1'b0))
                repeat_ok = 1'b0;
            if (!pulse_fits(dur, HDR_SPACE_US, 1'b0))
                data_ok = 1'b0;
        end
        else if (pos >= 3 && pos < 3 + 2 * DATA_BITS)
        begin
            if (pos == 7'd3 && !pulse_fits(dur, BIT_MARK_US, 1'b1))
                repeat_ok = 1'b0;
            // odd positions carry bit marks, even ones the bit spaces
            if (pos[0])
            begin
                if (!pulse_fits(dur, BIT_MARK_US, 1'b1))
                    data_ok = 1'b0;
            end
            else if (pulse_fits(dur, ONE_SPACE_US, 1'b0))
                bits_in = {bits_in[30:0], 1'b1};
            else if (pulse_fits(dur, ZERO_SPACE_US, 1'b0))
                bits_in = {bits_in[30:0], 1'b0};
            else
                data_ok = 1'b0;
        end
        if (capture_pos != POS_LIMIT)
            capture_pos = capture_pos + 7'd1;
        if (end_flag)
        begin
            result = '0;
            if (capture_pos == 7'd4 && repeat_ok)
            begin
                result.status = STATUS_REPEAT;
                result.value  = '1;
            end
            else if (capture_pos >= 2 * DATA_BITS + 4 && data_ok)
            begin
                result.status  = STATUS_DATA;
                result.value   = bits_in;
                result.address = flip_byte(bits_in[31:24]);
                result.command = flip_byte(bits_in[15:8]);
                result.nbits   = 6'(DATA_BITS);
            end
            frames_due.push_back(result);
            clear_capture();
        end
    endfunction

    function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %h, got %h", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        frame_t want;
        if (!rst_n)
        begin
            tick_us   = TICK_US_RST;
            tol_pct   = TOLERANCE_PCT_RST;
            excess_us = MARK_EXCESS_US_RST;
            frames_due.delete();
            clear_capture();
        end
        else
        begin
            if (frame_ch.valid && frame_ch.ready)
            begin
                if (frames_due.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: frame expected none, got status %0d value %h",
                             $time, frame_ch.status, frame_ch.frame_value);
                end
                else
                begin
                    want = frames_due.pop_front();
                    check_field("status", want.status, frame_ch.status);
                    check_field("frame_value", want.value, frame_ch.frame_value);
                    check_field("device_address", want.address, frame_ch.device_address);
                    check_field("key_command", want.command, frame_ch.key_command);
                    check_field("bit_count", want.nbits, frame_ch.bit_count);
                    case (want.status)
                        STATUS_DATA:   n_data++;
                        STATUS_REPEAT: n_repeat++;
                        default:       n_none++;
                    endcase
                end
            end
            if (pulse_ch.valid && pulse_ch.ready)
                take_pulse(pulse_ch.duration, pulse_ch.frame_start, pulse_ch.frame_end);
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[APB_ADDR_W-1:2])
                    REG_TICK_US:        tick_us   = pwdata[7:0];
                    REG_TOLERANCE_PCT:  tol_pct   = pwdata[5:0];
                    REG_MARK_EXCESS_US: excess_us = pwdata[7:0];
                    default: ;
                endcase
            end
        end
        errors          <= mismatches;
        pending         <= frames_due.size();
        data_frames     <= n_data;
        repeat_frames   <= n_repeat;
        rejected_frames <= n_none;
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// testbench top: clock, reset, register settings, pulse captures and the verdict
module tb;
    import nir_pkg::*;

    localparam int unsigned HDR_MARK_US   = 9000;
    localparam int unsigned HDR_SPACE_US  = 4500;
    localparam int unsigned BIT_MARK_US   = 560;
    localparam int unsigned ONE_SPACE_US  = 1690;
    localparam int unsigned ZERO_SPACE_US = 560;
    localparam int unsigned RPT_SPACE_US  = 2250;

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    int errors;
    int pending;
    int data_frames;
    int repeat_frames;
    int rejected_frames;

    // copy of the register values, used to size the pulses
    logic [7:0] tick_set;
    logic [5:0] tol_set;
    logic [7:0] excess_set;
    bit         steady_input;
    int         entries_sent = 0;
    int         captures_sent = 0;
    int         settings_used = 0;

    nir_in_if #(.DURATION_WIDTH(16)) pulse_ch ();
    nir_out_if                       frame_ch ();

    nec_ir_frame_decoder_unit u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .in_ch   (pulse_ch),
        .out_ch  (frame_ch)
    );

    nir_frame_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .pready          (pready),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pulse_ch        (pulse_ch),
        .frame_ch        (frame_ch),
        .errors          (errors),
        .pending         (pending),
        .data_frames     (data_frames),
        .repeat_frames   (repeat_frames),
        .rejected_frames (rejected_frames)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("tb failed");
        $finish;
    end

    function automatic int unsigned gap_len();
        int unsigned r;
        if (steady_input)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic int unsigned stall_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // smallest tick count not below the target; in the window for any nonzero tick
    function automatic int unsigned nominal_ticks(int unsigned us, bit is_mark);
        int unsigned target;
        target = is_mark ? us + excess_set : us - excess_set;
        if (tick_set == 0)
            return $urandom_range(0, 300);
        return (target + tick_set - 1) / tick_set;
    endfunction

    function automatic int unsigned jittered(int unsigned t);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 4)
            return t + 1;
        if (r < 8 && t > 0)
            return t - 1;
        return t;
    endfunction

    // setup and access phase; the caller drops psel after its last write
    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic apply_config(logic [7:0] t, logic [5:0] tol, logic [7:0] ex);
        write_reg(REG_TICK_US, ($urandom() & 32'hFFFF_FF00) | t);
        write_reg(REG_TOLERANCE_PCT, ($urandom() & 32'hFFFF_FFC0) | tol);
        write_reg(REG_MARK_EXCESS_US, ($urandom() & 32'hFFFF_FF00) | ex);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tick_set   = t;
        tol_set    = tol;
        excess_set = ex;
        settings_used++;
    endtask

    task automatic send_entry(logic [15:0] dur, bit start_flag, bit end_flag);
        int unsigned gap;
        gap = gap_len();
        if (gap > 0)
        begin
            pulse_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pulse_ch.valid       <= 1'b1;
        pulse_ch.duration    <= dur;
        pulse_ch.frame_start <= start_flag;
        pulse_ch.frame_end   <= end_flag;
        do @(posedge clk); while (!pulse_ch.ready);
        entries_sent++;
    endtask

    task automatic send_seq(int unsigned durs[$], bit with_start, bit with_end);
        for (int i = 0; i < durs.size(); i++)
            send_entry(16'(durs[i]), with_start && i == 0, with_end && i == durs.size() - 1);
    endtask

    // lets the pipeline drain, including entries that give no frame
    task automatic settle();
        pulse_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic send_data_frame();
        int unsigned seq[$];
        logic [31:0] word;
        int unsigned pick;
        word = $urandom();
        seq.push_back($urandom_range(0, 65535));
        seq.push_back(jittered(nominal_ticks(HDR_MARK_US, 1'b1)));
        seq.push_back(jittered(nominal_ticks(HDR_SPACE_US, 1'b0)));
        for (int i = 31; i >= 0; i--)
        begin
            seq.push_back(jittered(nominal_ticks(BIT_MARK_US, 1'b1)));
            seq.push_back(jittered(nominal_ticks(word[i] ? ONE_SPACE_US : ZERO_SPACE_US, 1'b0)));
        end
        seq.push_back(jittered(nominal_ticks(BIT_MARK_US, 1'b1)));
        pick = $urandom_range(0, 99);
        if (pick < 15)
            seq[$urandom_range(1, seq.size() - 1)] = $urandom_range(0, 65535);
        else if (pick < 27)
        begin
            // trailing entries, sometimes past the position limit
            repeat ($urandom_range(1, 70))
                seq.push_back($urandom_range(0, 65535));
        end
        else if (pick < 34)
        begin
            repeat ($urandom_range(1, 64))
                void'(seq.pop_back());
        end
        send_seq(seq, $urandom_range(0, 4) != 0, 1'b1);
    endtask

    task automatic send_repeat_code();
        int unsigned seq[$];
        int unsigned pick;
        seq.push_back($urandom_range(0, 65535));
        seq.push_back(jittered(nominal_ticks(HDR_MARK_US, 1'b1)));
        seq.push_back(jittered(nominal_ticks(RPT_SPACE_US, 1'b0)));
        seq.push_back(jittered(nominal_ticks(BIT_MARK_US, 1'b1)));
        pick = $urandom_range(0, 99);
        if (pick < 15)
            seq[$urandom_range(1, 3)] = $urandom_range(0, 65535);
        else if (pick < 25)
            seq.push_back(jittered(nominal_ticks(BIT_MARK_US, 1'b1)));
        send_seq(seq, $urandom_range(0, 4) != 0, 1'b1);
    endtask

    task automatic send_noise();
        int unsigned len;
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++)
            send_entry(16'($urandom()),
                       (i == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0),
                       (i == len - 1) ? ($urandom_range(0, 9) != 0)
                                      : ($urandom_range(0, 19) == 0));
    endtask

    task automatic random_capture();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            send_data_frame();
        else if (pick < 65)
            send_repeat_code();
        else
            send_noise();
        captures_sent++;
    endtask

    // result side: runs of ready broken by short and occasional long stalls
    initial
    begin
        frame_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            frame_ch.ready <= 1'b1;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 20))
                @(posedge clk);
            frame_ch.ready <= 1'b0;
            repeat (stall_len()) @(posedge clk);
        end
    end

    initial
    begin
        int unsigned seq[$];
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        pulse_ch.valid       <= 1'b0;
        pulse_ch.duration    <= '0;
        pulse_ch.frame_start <= 1'b0;
        pulse_ch.frame_end   <= 1'b0;
        tick_set     = TICK_US_RST;
        tol_set      = TOLERANCE_PCT_RST;
        excess_set   = MARK_EXCESS_US_RST;
        steady_input = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed captures under the reset register values
        seq = '{16'hFFFF, nominal_ticks(HDR_MARK_US, 1'b1), nominal_ticks(RPT_SPACE_US, 1'b0),
                nominal_ticks(BIT_MARK_US, 1'b1)};
        send_seq(seq, 1'b1, 1'b1);
        send_entry(16'h0000, 1'b1, 1'b1);
        // no start flag: the entry after an end opens a new capture
        send_entry(16'hFFFF, 1'b0, 1'b1);
        seq = '{0, 16'hFFFF, nominal_ticks(RPT_SPACE_US, 1'b0), nominal_ticks(BIT_MARK_US, 1'b1)};
        send_seq(seq, 1'b1, 1'b1);
        // start flag in the middle restarts the capture
        seq = '{123, nominal_ticks(HDR_MARK_US, 1'b1)};
        send_seq(seq, 1'b1, 1'b0);
        seq = '{77, nominal_ticks(HDR_MARK_US, 1'b1), nominal_ticks(RPT_SPACE_US, 1'b0),
                nominal_ticks(BIT_MARK_US, 1'b1)};
        send_seq(seq, 1'b1, 1'b1);
        send_seq(seq, 1'b0, 1'b1);
        seq[3] = 0;
        send_seq(seq, 1'b1, 1'b1);
        settle();

        while (entries_sent < 800 || captures_sent < 40)
        begin
            case (settings_used)
                0:       apply_config(8'd1, 6'd0, 8'd0);
                1:       apply_config(8'd255, 6'd50, 8'd255);
                2:       apply_config(8'd255, 6'd63, 8'd0);
                3:       apply_config(8'd0, 6'd25, 8'd100);
                4:       apply_config(TICK_US_RST, TOLERANCE_PCT_RST, MARK_EXCESS_US_RST);
                default: apply_config(8'($urandom_range(1, 255)), 6'($urandom_range(0, 63)),
                                      8'($urandom_range(0, 255)));
            endcase
            steady_input = ($urandom_range(0, 3) == 0);
            repeat (5) random_capture();
            settle();
        end
        repeat (20) @(posedge clk);

        $display("sent %0d pulse entries in random and directed captures under %0d settings",
                 entries_sent, settings_used + 1);
        $display("frames checked: %0d data, %0d repeat, %0d no match",
                 data_frames, repeat_frames, rejected_frames);
        if (errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
